[rtl/qte_pkg.sv]
// Shared types, constants and helpers for the quaternion to Euler angle pipeline.
`default_nettype none
package qte_pkg;

    localparam int XYW = 37;                // CORDIC x/y lane width
    localparam int ZW = 35;                 // CORDIC angle accumulator width, Q.30
    localparam int SQW = 62;                // square root remainder/root width
    localparam int SQRT_STAGES = 31;        // one result bit per cell
    localparam int ARGW = 34;               // atan2 argument width, Q2.30 doubled

    localparam logic signed [ZW-1:0] PI_Q30 = 35'sd3373259426;
    localparam logic signed [ARGW-1:0] ONE_Q30 = 34'sd1073741824;
    localparam logic [SQW-1:0] ONE_SQ = 62'd1 << 60;
    localparam logic signed [18:0] ANG_MAX = 19'sd25736;
    localparam logic [30:0] THR_RESET = 31'd1073731087;

    localparam logic [2:0] REG_LOCK_THR = 3'd0;

    localparam logic signed [ZW-1:0] ATAN_TAB [32] = '{
        35'sd843314857, 35'sd497837829, 35'sd263043837, 35'sd133525159,
        35'sd67021687, 35'sd33543516, 35'sd16775851, 35'sd8388437,
        35'sd4194283, 35'sd2097149, 35'sd1048576, 35'sd524288,
        35'sd262144, 35'sd131072, 35'sd65536, 35'sd32768,
        35'sd16384, 35'sd8192, 35'sd4096, 35'sd2048,
        35'sd1024, 35'sd512, 35'sd256, 35'sd128,
        35'sd64, 35'sd32, 35'sd16, 35'sd8,
        35'sd4, 35'sd2, 35'sd1, 35'sd0
    };

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } t_quat;

    typedef struct packed {
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
        logic               gimbal_locked;
    } t_euler;

    typedef struct packed {
        logic signed [XYW-1:0] x;
        logic signed [XYW-1:0] y;
        logic signed [ZW-1:0]  z;
        logic                  zero;
    } t_lane;

    typedef struct packed {
        logic [SQW-1:0] rem;
        logic [SQW-1:0] root;
    } t_root;

    // Round half up from Q.30 to Q3.13 and saturate.
    function automatic logic signed [15:0] to_q13(input logic signed [ZW-1:0] a);
        logic signed [ZW:0] sum;
        logic signed [18:0] r;
        sum = (ZW+1)'(a) + (ZW+1)'(65536);
        r = 19'(sum >>> 17);
        if (r > ANG_MAX) begin
            r = ANG_MAX;
        end else if (r < -ANG_MAX) begin
            r = -ANG_MAX;
        end
        return r[15:0];
    endfunction

endpackage
`default_nettype wire

[rtl/qte_sqrt_cell.sv]
// One restoring square root cell: settles one root bit per clock.
`default_nettype none
module qte_sqrt_cell #(
    parameter int K = 0
) (
    input  wire                 i_clk,
    input  qte_pkg::t_root      i_root,
    output qte_pkg::t_root      o_root
);

    localparam logic [qte_pkg::SQW-1:0] BIT = qte_pkg::SQW'(1) << (2 * K);

    logic [qte_pkg::SQW-1:0] trial;
    qte_pkg::t_root          n_root;
    qte_pkg::t_root          r_root;

    always_comb begin
        trial = i_root.root + BIT;
        if (i_root.rem >= trial) begin
            n_root.rem  = i_root.rem - trial;
            n_root.root = (i_root.root >> 1) + BIT;
        end else begin
            n_root.rem  = i_root.rem;
            n_root.root = i_root.root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_root <= n_root;
    end

    assign o_root = r_root;

endmodule
`default_nettype wire

[rtl/qte_cordic_cell.sv]
// One vectoring CORDIC micro-rotation with its own fixed shift and angle.
`default_nettype none
module qte_cordic_cell #(
    parameter int STAGE = 0
) (
    input  wire                 i_clk,
    input  qte_pkg::t_lane      i_lane,
    output qte_pkg::t_lane      o_lane
);

    localparam logic [4:0] IDX = STAGE[4:0];
    localparam logic signed [qte_pkg::ZW-1:0] ANG = qte_pkg::ATAN_TAB[IDX];

    logic signed [qte_pkg::XYW-1:0] dx;
    logic signed [qte_pkg::XYW-1:0] dy;
    qte_pkg::t_lane                 n_lane;
    qte_pkg::t_lane                 r_lane;

    always_comb begin
        dx = i_lane.y >>> STAGE;
        dy = i_lane.x >>> STAGE;
        n_lane.zero = i_lane.zero;
        if (i_lane.y > 0) begin
            n_lane.x = i_lane.x + dx;
            n_lane.y = i_lane.y - dy;
            n_lane.z = i_lane.z + ANG;
        end else begin
            n_lane.x = i_lane.x - dx;
            n_lane.y = i_lane.y + dy;
            n_lane.z = i_lane.z - ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
    end

    assign o_lane = r_lane;

endmodule
`default_nettype wire

[rtl/quaternion_to_euler_xyz.sv]
// Top level: unit quaternion in, XYZ Euler angles and gimbal lock flag out.
// One quaternion is taken every clock (busy stays low) and its result appears on
// o_result with o_valid once it has passed, in order, the input register, the
// products, the sums, the lock decision, the squaring, 31 square root cells for
// cos of the middle angle, a pre-rotation register, CORDIC_STAGES CORDIC cells
// run as three parallel lanes, and a rounding register. The receiver has no
// back-pressure, so each o_result is valid for a single cycle only.
`default_nettype none
module quaternion_to_euler_xyz #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    output logic                busy,
    input  qte_pkg::t_quat      i_quat,
    output logic                o_valid,
    output qte_pkg::t_euler     o_result,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [2:0]          paddr,
    input  wire  [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int NS = qte_pkg::SQRT_STAGES;
    localparam int LAT = 38 + CORDIC_STAGES;
    localparam int AW = qte_pkg::ARGW;
    localparam int XW = qte_pkg::XYW;

    typedef struct packed {
        logic signed [AW-1:0] ax_y;
        logic signed [AW-1:0] ax_x;
        logic signed [AW-1:0] az_y;
        logic signed [AW-1:0] az_x;
        logic signed [31:0]   sc;
        logic                 locked;
    } t_pass;

    logic                   accept;
    logic [30:0]            r_thr;
    logic [LAT-1:0]         r_vld;

    qte_pkg::t_quat         r_q;
    logic signed [31:0]     r_xz, r_yw, r_xw, r_yz, r_ww, r_zz, r_xx, r_xy, r_yy, r_zw;
    logic signed [AW-1:0]   r_s, r_axu_y, r_axu_x, r_azu_y, r_azu_x, r_axl_y, r_axl_x;
    logic signed [AW-1:0]   mag;
    logic signed [31:0]     sc;
    t_pass                  n_p3;
    t_pass                  r_p3;
    logic [30:0]            r_asc;
    t_pass                  r_p4;
    logic [qte_pkg::SQW-1:0] r_sq;

    qte_pkg::t_root         root [NS+1];
    t_pass                  r_pas [NS];

    qte_pkg::t_lane         lane_x [CORDIC_STAGES+1];
    qte_pkg::t_lane         lane_y [CORDIC_STAGES+1];
    qte_pkg::t_lane         lane_z [CORDIC_STAGES+1];
    logic                   r_lk [CORDIC_STAGES+1];
    qte_pkg::t_euler        r_res;

    function automatic qte_pkg::t_lane prep(input logic signed [XW-1:0] y,
                                            input logic signed [XW-1:0] x);
        qte_pkg::t_lane l;
        l.zero = (x == '0) && (y == '0);
        if (x < 0) begin
            l.z = (y >= 0) ? qte_pkg::PI_Q30 : -qte_pkg::PI_Q30;
            l.x = -x;
            l.y = -y;
        end else begin
            l.z = '0;
            l.x = x;
            l.y = y;
        end
        return l;
    endfunction

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign pready = 1'b1;
    assign prdata = {1'b0, r_thr};

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= qte_pkg::THR_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr >> 2) == qte_pkg::REG_LOCK_THR) begin
            r_thr <= pwdata[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], accept};
        end
    end

    // products, sums
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q <= i_quat;
        end
        r_xz <= r_q.quat_x * r_q.quat_z;
        r_yw <= r_q.quat_y * r_q.quat_w;
        r_xw <= r_q.quat_x * r_q.quat_w;
        r_yz <= r_q.quat_y * r_q.quat_z;
        r_ww <= r_q.quat_w * r_q.quat_w;
        r_zz <= r_q.quat_z * r_q.quat_z;
        r_xx <= r_q.quat_x * r_q.quat_x;
        r_xy <= r_q.quat_x * r_q.quat_y;
        r_yy <= r_q.quat_y * r_q.quat_y;
        r_zw <= r_q.quat_z * r_q.quat_w;
        r_s     <= (AW'(r_xz) + AW'(r_yw)) <<< 1;
        r_axu_y <= (AW'(r_xw) - AW'(r_yz)) <<< 1;
        r_axu_x <= ((AW'(r_ww) + AW'(r_zz)) <<< 1) - qte_pkg::ONE_Q30;
        r_azu_y <= (AW'(r_zw) - AW'(r_xy)) <<< 1;
        r_azu_x <= ((AW'(r_ww) + AW'(r_xx)) <<< 1) - qte_pkg::ONE_Q30;
        r_axl_y <= (AW'(r_yz) + AW'(r_xw)) <<< 1;
        r_axl_x <= ((AW'(r_ww) + AW'(r_yy)) <<< 1) - qte_pkg::ONE_Q30;
    end

    // lock decision, clamp, argument choice
    always_comb begin
        mag = (r_s < 0) ? -r_s : r_s;
        if (r_s > qte_pkg::ONE_Q30) begin
            sc = 32'(qte_pkg::ONE_Q30);
        end else if (r_s < -qte_pkg::ONE_Q30) begin
            sc = -32'(qte_pkg::ONE_Q30);
        end else begin
            sc = r_s[31:0];
        end
        n_p3.locked = !(mag < $signed({3'b000, r_thr}));
        n_p3.sc     = sc;
        n_p3.az_y   = r_azu_y;
        n_p3.az_x   = r_azu_x;
        if (n_p3.locked) begin
            n_p3.ax_y = r_axl_y;
            n_p3.ax_x = r_axl_x;
        end else begin
            n_p3.ax_y = r_axu_y;
            n_p3.ax_x = r_axu_x;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p3  <= n_p3;
        r_asc <= (sc < 0) ? 31'(-sc) : sc[30:0];
        r_p4  <= r_p3;
        r_sq  <= 62'(r_asc) * 62'(r_asc);
    end

    // square root chain: cos = sqrt(1 - s*s)
    assign root[0].rem  = qte_pkg::ONE_SQ - r_sq;
    assign root[0].root = '0;

    genvar gs;
    generate
        for (gs = 0; gs < NS; gs++) begin : g_sqrt
            qte_sqrt_cell #(.K(NS - 1 - gs)) u_cell (
                .i_clk  (i_clk),
                .i_root (root[gs]),
                .o_root (root[gs+1])
            );
            if (gs == 0) begin : g_first
                always_ff @(posedge i_clk) begin
                    r_pas[gs] <= r_p4;
                end
            end else begin : g_next
                always_ff @(posedge i_clk) begin
                    r_pas[gs] <= r_pas[gs-1];
                end
            end
        end
    endgenerate

    // quadrant pre-rotation
    always_ff @(posedge i_clk) begin
        lane_x[0] <= prep(XW'(r_pas[NS-1].ax_y), XW'(r_pas[NS-1].ax_x));
        lane_y[0] <= prep(XW'(r_pas[NS-1].sc), XW'(root[NS].root[30:0]));
        lane_z[0] <= prep(XW'(r_pas[NS-1].az_y), XW'(r_pas[NS-1].az_x));
        r_lk[0]   <= r_pas[NS-1].locked;
    end

    genvar gc;
    generate
        for (gc = 0; gc < CORDIC_STAGES; gc++) begin : g_cordic
            qte_cordic_cell #(.STAGE(gc)) u_cx (
                .i_clk (i_clk), .i_lane (lane_x[gc]), .o_lane (lane_x[gc+1])
            );
            qte_cordic_cell #(.STAGE(gc)) u_cy (
                .i_clk (i_clk), .i_lane (lane_y[gc]), .o_lane (lane_y[gc+1])
            );
            qte_cordic_cell #(.STAGE(gc)) u_cz (
                .i_clk (i_clk), .i_lane (lane_z[gc]), .o_lane (lane_z[gc+1])
            );
            always_ff @(posedge i_clk) begin
                r_lk[gc+1] <= r_lk[gc];
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        r_res.angle_x <= lane_x[CORDIC_STAGES].zero ? 16'sd0
                         : qte_pkg::to_q13(lane_x[CORDIC_STAGES].z);
        r_res.angle_y <= lane_y[CORDIC_STAGES].zero ? 16'sd0
                         : qte_pkg::to_q13(lane_y[CORDIC_STAGES].z);
        r_res.angle_z <= (lane_z[CORDIC_STAGES].zero || r_lk[CORDIC_STAGES]) ? 16'sd0
                         : qte_pkg::to_q13(lane_z[CORDIC_STAGES].z);
        r_res.gimbal_locked <= r_lk[CORDIC_STAGES];
    end

    assign o_valid  = r_vld[LAT-1];
    assign o_result = r_res;

    a_lock_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.gimbal_locked |-> o_result.angle_z == 16'sd0)
        else $error("third angle not zero under gimbal lock");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result.angle_y <= 16'sd25736 && o_result.angle_y >= -16'sd25736
                 && o_result.angle_x <= 16'sd25736 && o_result.angle_x >= -16'sd25736)
        else $error("angle outside saturation range");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result without matching start transfer");

endmodule
`default_nettype wire
